### rtl/tccb_pkg.sv
// Package for the three-camera column blend: types, register map, reset values
// and the per-channel rounding and blend functions.
// No dependencies.
package tccb_pkg;

  localparam int COLUMN_W = 12;
  localparam int SIZE_W   = 13;
  localparam int PIXEL_W  = 24;
  localparam int COUNT_W  = 2;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [1:0] REG_LINE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_TAIL_WIDTH  = 2'd1;
  localparam logic [1:0] REG_MASK_ENABLE = 2'd2;

  localparam logic [SIZE_W-1:0] LINE_WIDTH_RESET = 13'd2400;
  localparam logic [SIZE_W-1:0] TAIL_WIDTH_RESET = 13'd960;
  localparam logic              MASK_ENABLE_RESET = 1'b1;

  localparam logic [7:0] VALID_LEVEL = 8'd10;
  localparam logic [7:0] CHAN_MAX    = 8'd255;

  typedef logic [PIXEL_W-1:0] pixel_t;

  typedef struct packed {
    logic [SIZE_W-1:0] line_width;
    logic [SIZE_W-1:0] tail_width;
    logic              mask_enable;
  } cfg_t;

  typedef struct packed {
    logic left;
    logic centre;
    logic right;
  } keep_t;

  // any channel above the black level
  function automatic logic pix_valid(input pixel_t p);
    return (p[7:0] > VALID_LEVEL) || (p[15:8] > VALID_LEVEL) || (p[23:16] > VALID_LEVEL);
  endfunction

  // v/2, round half to even
  function automatic logic [7:0] half_rhe(input logic [7:0] v);
    return {1'b0, v[7:1]} + {7'd0, v[0] & v[1]};
  endfunction

  // v/4, round half to even
  function automatic logic [7:0] quarter_rhe(input logic [7:0] v);
    logic up;
    up = (v[1] & v[0]) | (v[1] & ~v[0] & v[2]);
    return {2'b00, v[7:2]} + {7'd0, up};
  endfunction

  function automatic logic [7:0] sat_chan(input logic [8:0] s);
    return s[8] ? CHAN_MAX : s[7:0];
  endfunction

  // 1/2 + 1/2 blend, per channel
  function automatic pixel_t pair_blend(input pixel_t a, input pixel_t b);
    pixel_t res;
    logic [8:0] sum;
    for (int k = 0; k < 3; k++) begin
      sum = {1'b0, half_rhe(a[8*k +: 8])} + {1'b0, half_rhe(b[8*k +: 8])};
      res[8*k +: 8] = sat_chan(sum);
    end
    return res;
  endfunction

  // 1/4 left + 1/2 centre + 1/4 right, per channel
  function automatic pixel_t tri_blend(input pixel_t l, input pixel_t c, input pixel_t r);
    pixel_t res;
    logic [8:0] sum;
    for (int k = 0; k < 3; k++) begin
      sum = {1'b0, quarter_rhe(l[8*k +: 8])} + {1'b0, half_rhe(c[8*k +: 8])}
          + {1'b0, quarter_rhe(r[8*k +: 8])};
      res[8*k +: 8] = sat_chan(sum);
    end
    return res;
  endfunction

endpackage

### rtl/tccb_if.sv
// Stream interfaces of the column blend: camera pixel input and blended output.
// Depends on tccb_pkg.
interface tccb_in_if;
  logic                         valid;
  logic                         ready;
  logic [tccb_pkg::COLUMN_W-1:0] column;
  tccb_pkg::pixel_t             left_pixel;
  tccb_pkg::pixel_t             centre_pixel;
  tccb_pkg::pixel_t             right_pixel;

  modport source (output valid, column, left_pixel, centre_pixel, right_pixel, input ready);
  modport sink (input valid, column, left_pixel, centre_pixel, right_pixel, output ready);
endinterface

interface tccb_out_if;
  logic                         valid;
  logic                         ready;
  tccb_pkg::pixel_t             blended_pixel;
  logic [tccb_pkg::COUNT_W-1:0] source_count;

  modport source (output valid, blended_pixel, source_count, input ready);
  modport sink (input valid, blended_pixel, source_count, output ready);
endinterface

### rtl/tccb_window.sv
// Column window tests for the left, centre and right camera.
// Depends on tccb_pkg.
module tccb_window (
  input  tccb_pkg::cfg_t                cfg,
  input  logic [tccb_pkg::COLUMN_W-1:0] column,
  output tccb_pkg::keep_t               keep
);

  logic signed [13:0] diff;
  logic signed [13:0] cs;
  logic signed [25:0] xs;
  logic signed [25:0] ws;
  logic signed [25:0] ts;
  logic signed [25:0] cs_ext;
  logic signed [25:0] ce_ext;
  logic               left_in;
  logic               right_in;
  logic               centre_in;

  always_comb begin
    diff   = $signed({1'b0, cfg.line_width}) - $signed({1'b0, cfg.tail_width});
    // halve, truncating toward zero
    cs     = (diff >>> 1) + $signed({13'd0, diff[13] & diff[0]});
    xs     = $signed({14'd0, column});
    ws     = $signed({13'd0, cfg.line_width});
    ts     = $signed({13'd0, cfg.tail_width});
    cs_ext = {{12{cs[13]}}, cs};
    ce_ext = cs_ext + ts;

    left_in   = (26'sd510 * (xs - ws) + 26'sd764 * ts) >= 26'sd0;
    right_in  = (26'sd510 * xs) <= (26'sd764 * ts);
    centre_in = ((26'sd1020 * (cs_ext - xs)) <= (26'sd254 * ts))
             && ((26'sd1020 * (xs - ce_ext)) <= (26'sd254 * ts));

    keep.left   = !cfg.mask_enable || left_in;
    keep.centre = !cfg.mask_enable || centre_in;
    keep.right  = !cfg.mask_enable || right_in;
  end

endmodule

### rtl/tccb_blend.sv
// Validity test, source count and weighted blend of three masked pixels.
// Depends on tccb_pkg.
module tccb_blend (
  input  tccb_pkg::pixel_t             left_pixel,
  input  tccb_pkg::pixel_t             centre_pixel,
  input  tccb_pkg::pixel_t             right_pixel,
  output tccb_pkg::pixel_t             blended_pixel,
  output logic [tccb_pkg::COUNT_W-1:0] source_count
);

  logic vl;
  logic vc;
  logic vr;

  always_comb begin
    vl = tccb_pkg::pix_valid(left_pixel);
    vc = tccb_pkg::pix_valid(centre_pixel);
    vr = tccb_pkg::pix_valid(right_pixel);
    source_count = {1'b0, vl} + {1'b0, vc} + {1'b0, vr};
    unique case ({vl, vc, vr})
      3'b000: blended_pixel = '0;
      3'b100: blended_pixel = left_pixel;
      3'b010: blended_pixel = centre_pixel;
      3'b001: blended_pixel = right_pixel;
      3'b110: blended_pixel = tccb_pkg::pair_blend(left_pixel, centre_pixel);
      3'b011: blended_pixel = tccb_pkg::pair_blend(centre_pixel, right_pixel);
      3'b101: blended_pixel = tccb_pkg::pair_blend(left_pixel, right_pixel);
      default: blended_pixel = tccb_pkg::tri_blend(left_pixel, centre_pixel, right_pixel);
    endcase
  end

endmodule

### rtl/three_camera_column_blend_unit.sv
// Top level of the three-camera column blend: APB register file, input and
// result registers. Depends on tccb_pkg, tccb_if, tccb_window and tccb_blend.
//
//   channel    kind        payload
//   cameras    stream in   column, left_pixel, centre_pixel, right_pixel
//   stitched   stream out  blended_pixel, source_count
//   apb        register    line_width @0x0, tail_width @0x4, mask_enable @0x8
//
// One pixel per clock sustained while the output is not stalled. Each pixel
// passes through the input register, then through the window and blend logic
// into the result register, from which it transfers out. Synchronous
// active-high reset empties both registers and restores the register defaults.
// A stalled output holds the result register; the input register keeps
// accepting until it is full behind it.
module three_camera_column_blend_unit (
  input  logic                                clk,
  input  logic                                rst,
  tccb_in_if.sink                             cameras,
  tccb_out_if.source                          stitched,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tccb_pkg::PADDR_W-1:0]        paddr,
  input  logic [tccb_pkg::PDATA_W-1:0]        pwdata,
  output logic [tccb_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  tccb_pkg::cfg_t                cfg;
  logic                          cfg_write;
  logic [1:0]                    reg_index;

  logic                          s1_valid;
  logic [tccb_pkg::COLUMN_W-1:0] s1_column;
  tccb_pkg::pixel_t              s1_left;
  tccb_pkg::pixel_t              s1_centre;
  tccb_pkg::pixel_t              s1_right;

  logic                          out_valid;
  tccb_pkg::pixel_t              out_pixel;
  logic [tccb_pkg::COUNT_W-1:0]  out_count;

  tccb_pkg::keep_t               keep;
  tccb_pkg::pixel_t              masked_left;
  tccb_pkg::pixel_t              masked_centre;
  tccb_pkg::pixel_t              masked_right;
  tccb_pkg::pixel_t              blend_pixel;
  logic [tccb_pkg::COUNT_W-1:0]  blend_count;

  logic                          advance;
  logic                          in_xfer;

  // ---------------------------------------------------------------------------
  // Register port: zero-wait APB, word-aligned registers
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width  <= tccb_pkg::LINE_WIDTH_RESET;
      cfg.tail_width  <= tccb_pkg::TAIL_WIDTH_RESET;
      cfg.mask_enable <= tccb_pkg::MASK_ENABLE_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        tccb_pkg::REG_LINE_WIDTH:  cfg.line_width  <= pwdata[tccb_pkg::SIZE_W-1:0];
        tccb_pkg::REG_TAIL_WIDTH:  cfg.tail_width  <= pwdata[tccb_pkg::SIZE_W-1:0];
        tccb_pkg::REG_MASK_ENABLE: cfg.mask_enable <= pwdata[0];
        default: ;  // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      tccb_pkg::REG_LINE_WIDTH:  prdata = {19'd0, cfg.line_width};
      tccb_pkg::REG_TAIL_WIDTH:  prdata = {19'd0, cfg.tail_width};
      tccb_pkg::REG_MASK_ENABLE: prdata = {31'd0, cfg.mask_enable};
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: the result register moves whenever it is empty or being taken;
  // the input register refills whenever it is empty or moving forward.
  // ---------------------------------------------------------------------------
  assign advance       = !out_valid || stitched.ready;
  assign cameras.ready = !s1_valid || advance;
  assign in_xfer       = cameras.valid && cameras.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cameras.ready) begin
      s1_valid <= cameras.valid;
    end
  end

  // payload needs no reset; load only on a transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_column <= cameras.column;
      s1_left   <= cameras.left_pixel;
      s1_centre <= cameras.centre_pixel;
      s1_right  <= cameras.right_pixel;
    end
  end

  // ---------------------------------------------------------------------------
  // Window tests, masking and blend between the two registers
  // ---------------------------------------------------------------------------
  tccb_window u_window (
    .cfg    (cfg),
    .column (s1_column),
    .keep   (keep)
  );

  // black out a pixel outside its camera's window
  assign masked_left   = keep.left   ? s1_left   : '0;
  assign masked_centre = keep.centre ? s1_centre : '0;
  assign masked_right  = keep.right  ? s1_right  : '0;

  tccb_blend u_blend (
    .left_pixel    (masked_left),
    .centre_pixel  (masked_centre),
    .right_pixel   (masked_right),
    .blended_pixel (blend_pixel),
    .source_count  (blend_count)
  );

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_pixel <= blend_pixel;
      out_count <= blend_count;
    end
  end

  assign stitched.valid         = out_valid;
  assign stitched.blended_pixel = out_pixel;
  assign stitched.source_count  = out_count;

`ifndef SYNTHESIS
  // no valid source means a black result
  a_black_when_empty: assert property (@(posedge clk) disable iff (rst)
    (stitched.valid && stitched.source_count == 2'd0) |-> stitched.blended_pixel == '0)
    else $error("nonzero pixel with no valid source");

  // an item leaving the input register lands in the result register
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> out_valid)
    else $error("item dropped between input and result register");

  // a mask_enable write takes effect on the next cycle
  a_mask_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && reg_index == tccb_pkg::REG_MASK_ENABLE) |=> cfg.mask_enable == $past(pwdata[0]))
    else $error("mask_enable write lost");
`endif

endmodule
